FILE: design/nvme_io_queue_request_engine_top_assert.svh
// Assertion macros for the NVMe I/O queue request engine.
`ifndef NVME_IO_QUEUE_REQUEST_ENGINE_TOP_ASSERT_SVH
`define NVME_IO_QUEUE_REQUEST_ENGINE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Checks that the property holds at every clock edge outside reset.
`define NQRE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("nvme queue engine: property violated");
// Checks that the condition never holds outside reset.
`define NQRE_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("nvme queue engine: forbidden condition seen");
`else
`define NQRE_ASSERT(lbl, clk, rstn, prop)
`define NQRE_NEVER(lbl, clk, rstn, cond)
`endif
`endif

FILE: design/nvme_qre_pkg.sv
// Types, codes and constants of the NVMe I/O queue request engine.
package nvme_qre_pkg;

    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int BUFFER_BYTES_DEF = 4096;

    localparam int LBA_W      = 48;
    localparam int COUNT_W    = 32;
    localparam int CID_W      = 16;
    localparam int STATUS_W   = 16;
    localparam int SLOT_W     = 4;
    localparam int BM1_W      = 12;
    localparam int DB_W       = 19;
    localparam int CHUNK_W    = 13;
    localparam int MAX_CHUNK  = 4096;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [DB_W-1:0] DOORBELL_BASE  = 19'h01000;
    localparam logic [DB_W-1:0] DB_STRIDE_UNIT = 19'd4;

    // Output FIFO of result beats.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam logic ACT_REQUEST    = 1'b0;
    localparam logic ACT_COMPLETION = 1'b1;

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [2:0] KIND_ISSUED   = 3'd0;
    localparam logic [2:0] KIND_CONSUMED = 3'd1;
    localparam logic [2:0] KIND_IGNORED  = 3'd2;
    localparam logic [2:0] KIND_REJECTED = 3'd3;
    localparam logic [2:0] KIND_FAILED   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_LBA_SHIFT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECTOR_TOTAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NAMESPACE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_SHIFT = 2'd3;

    typedef struct packed {
        logic                action;
        logic [LBA_W-1:0]    start_lba;
        logic [COUNT_W-1:0]  block_count;
        logic                is_write;
        logic [CID_W-1:0]    entry_cid;
        logic [STATUS_W-1:0] entry_status;
    } t_item;

    typedef struct packed {
        logic [2:0]          kind;
        logic [1:0]          opcode;
        logic [CID_W-1:0]    command_id;
        logic [SLOT_W-1:0]   sq_slot;
        logic [LBA_W-1:0]    cmd_lba;
        logic [BM1_W-1:0]    blocks_minus_one;
        logic [DB_W-1:0]     doorbell_offset;
        logic [SLOT_W-1:0]   doorbell_value;
        logic [STATUS_W-1:0] error_status;
        logic                request_done;
        logic                last;
    } t_result;

endpackage

FILE: design/nvme_io_queue_request_engine_top.sv
// Top level of the NVMe I/O queue request engine (host side of one queue pair).
//
// Usage. Items arrive on the request channel (i_req_valid / o_req_ready). An item is
// either a new block request or a completion entry read at the completion queue head,
// selected by i_action. Result beats leave on the result channel (o_res_valid /
// i_res_ready); each item yields one or two beats, and o_last marks the final beat of
// an item. Configuration registers are written through i_cfg_we, i_cfg_index and
// i_cfg_data, and should only be written while the engine is idle.
//
// Flow. An accepted item is decided while it sits in the input register, and its beats
// enter a four-entry result FIFO at the following edge; the first beat is visible on the
// port once it has been written there. The result port delivers one beat per cycle while
// i_res_ready is high, so the engine then sustains one item per cycle while items yield
// a single beat; items that yield two beats (a good completion followed by the next
// chunk) outrun the port, and the input side then holds until the FIFO drains. The input
// register is decided only when the FIFO has room for two beats.
//
// Reset (synchronous, active low) empties both stages, sets the engine idle with the
// phase tag at one and restores the register defaults. When the receiver stalls, beats
// collect in the FIFO and the input side stops once it would overflow.
`include "nvme_io_queue_request_engine_top_assert.svh"

module nvme_io_queue_request_engine_top #(
    parameter int QUEUE_DEPTH  = nvme_qre_pkg::QUEUE_DEPTH_DEF,
    parameter int BUFFER_BYTES = nvme_qre_pkg::BUFFER_BYTES_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration write port
    input  logic                                   i_cfg_we,
    input  logic [nvme_qre_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [nvme_qre_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Request channel
    input  logic                                   i_req_valid,
    output logic                                   o_req_ready,
    input  logic                                   i_action,
    input  logic [nvme_qre_pkg::LBA_W-1:0]         i_start_lba,
    input  logic [nvme_qre_pkg::COUNT_W-1:0]       i_block_count,
    input  logic                                   i_is_write,
    input  logic [nvme_qre_pkg::CID_W-1:0]         i_entry_cid,
    input  logic [nvme_qre_pkg::STATUS_W-1:0]      i_entry_status,
    // Result channel
    output logic                                   o_res_valid,
    input  logic                                   i_res_ready,
    output logic [2:0]                             o_kind,
    output logic [1:0]                             o_opcode,
    output logic [nvme_qre_pkg::CID_W-1:0]         o_command_id,
    output logic [nvme_qre_pkg::SLOT_W-1:0]        o_sq_slot,
    output logic [nvme_qre_pkg::LBA_W-1:0]         o_cmd_lba,
    output logic [nvme_qre_pkg::BM1_W-1:0]         o_blocks_minus_one,
    output logic [nvme_qre_pkg::DB_W-1:0]          o_doorbell_offset,
    output logic [nvme_qre_pkg::SLOT_W-1:0]        o_doorbell_value,
    output logic [nvme_qre_pkg::STATUS_W-1:0]      o_error_status,
    output logic                                   o_request_done,
    output logic                                   o_last
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int BW = $clog2(BUFFER_BYTES + 1);
    localparam logic [QW-1:0] QUEUE_LAST = QW'(QUEUE_DEPTH - 1);

    // Configuration registers. The namespace identifier reaches no result field,
    // so a write to it is accepted and has no further effect.
    logic [3:0]                            r_lba_shift;
    logic [nvme_qre_pkg::LBA_W-1:0]        r_sector_total;
    logic [3:0]                            r_stride_shift;

    // Input register
    logic                                  r_in_valid;
    nvme_qre_pkg::t_item                   r_in;

    // Queue pair state
    logic                                  r_busy,        n_busy;
    logic [nvme_qre_pkg::COUNT_W-1:0]      r_remaining,   n_remaining;
    logic [nvme_qre_pkg::LBA_W-1:0]        r_next_lba,    n_next_lba;
    logic                                  r_write_flag,  n_write_flag;
    logic [nvme_qre_pkg::CID_W-1:0]        r_cmd_cnt,     n_cmd_cnt;
    logic [nvme_qre_pkg::CID_W-1:0]        r_pending_cid, n_pending_cid;
    logic [QW-1:0]                         r_sq_tail,     n_sq_tail;
    logic [QW-1:0]                         r_cq_head,     n_cq_head;
    logic                                  r_phase,       n_phase;

    // Result FIFO
    nvme_qre_pkg::t_result                 r_fifo [nvme_qre_pkg::FIFO_DEPTH];
    logic [nvme_qre_pkg::FIFO_PTR_W-1:0]   r_wr_ptr;
    logic [nvme_qre_pkg::FIFO_PTR_W-1:0]   r_rd_ptr;
    logic [nvme_qre_pkg::FIFO_CNT_W-1:0]   r_count;

    logic                                  proc_fire;
    logic                                  pop;
    logic [1:0]                            push_n;
    nvme_qre_pkg::t_result                 res_a;
    nvme_qre_pkg::t_result                 res_b;
    nvme_qre_pkg::t_result                 res_issue;
    nvme_qre_pkg::t_result                 res_head;
    logic                                  do_issue;

    logic [BW-1:0]                         buf_shifted;
    logic [nvme_qre_pkg::CHUNK_W-1:0]      chunk_lim;
    logic [nvme_qre_pkg::CHUNK_W-1:0]      chunk;
    logic [nvme_qre_pkg::COUNT_W-1:0]      src_rem;
    logic [nvme_qre_pkg::LBA_W-1:0]        src_lba;
    logic                                  src_wr;
    logic [nvme_qre_pkg::CID_W-1:0]        cid_next;
    logic [QW-1:0]                         tail_next;
    logic [QW-1:0]                         head_next;
    logic [nvme_qre_pkg::DB_W-1:0]         stride_b;
    logic [nvme_qre_pkg::DB_W-1:0]         sq_db;
    logic [nvme_qre_pkg::DB_W-1:0]         cq_db;
    logic [nvme_qre_pkg::LBA_W:0]          req_end;
    logic                                  reject;
    logic                                  ignore;

    // ---------------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------------
    // The held item is decided once the FIFO has room for two beats.
    assign proc_fire   = r_in_valid && (r_count <= nvme_qre_pkg::FIFO_CNT_W'(2));
    assign o_req_ready = !r_in_valid || proc_fire;
    assign o_res_valid = (r_count != '0);
    assign pop         = o_res_valid && i_res_ready;

    // ---------------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lba_shift    <= 4'd9;
            r_sector_total <= '0;
            r_stride_shift <= 4'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                nvme_qre_pkg::REG_LBA_SHIFT:    r_lba_shift    <= i_cfg_data[3:0];
                nvme_qre_pkg::REG_SECTOR_TOTAL: r_sector_total <= i_cfg_data;
                nvme_qre_pkg::REG_NAMESPACE:    ;
                nvme_qre_pkg::REG_STRIDE_SHIFT: r_stride_shift <= i_cfg_data[3:0];
                default:                        ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_req_ready) begin
            r_in_valid <= i_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_ready && i_req_valid) begin
            r_in.action       <= i_action;
            r_in.start_lba    <= i_start_lba;
            r_in.block_count  <= i_block_count;
            r_in.is_write     <= i_is_write;
            r_in.entry_cid    <= i_entry_cid;
            r_in.entry_status <= i_entry_status;
        end
    end

    // ---------------------------------------------------------------------
    // Shared arithmetic
    // ---------------------------------------------------------------------
    // Blocks that fit the data buffer, capped so that the length fits 12 bits.
    assign buf_shifted = BW'(BUFFER_BYTES) >> r_lba_shift;
    assign chunk_lim   = (32'(buf_shifted) > 32'(nvme_qre_pkg::MAX_CHUNK))
                       ? nvme_qre_pkg::CHUNK_W'(nvme_qre_pkg::MAX_CHUNK)
                       : nvme_qre_pkg::CHUNK_W'(buf_shifted);

    // A new request issues from its own fields, a good completion from the state.
    assign src_rem = (r_in.action == nvme_qre_pkg::ACT_REQUEST) ? r_in.block_count : r_remaining;
    assign src_lba = (r_in.action == nvme_qre_pkg::ACT_REQUEST) ? r_in.start_lba : r_next_lba;
    assign src_wr  = (r_in.action == nvme_qre_pkg::ACT_REQUEST) ? r_in.is_write : r_write_flag;

    assign chunk = (src_rem > nvme_qre_pkg::COUNT_W'(chunk_lim))
                 ? chunk_lim : src_rem[nvme_qre_pkg::CHUNK_W-1:0];

    assign cid_next  = r_cmd_cnt + 1'b1;
    assign tail_next = (r_sq_tail == QUEUE_LAST) ? '0 : r_sq_tail + 1'b1;
    assign head_next = (r_cq_head == QUEUE_LAST) ? '0 : r_cq_head + 1'b1;

    // Submission doorbell sits two strides above the base, completion three.
    assign stride_b = nvme_qre_pkg::DB_STRIDE_UNIT << r_stride_shift;
    assign sq_db    = nvme_qre_pkg::DOORBELL_BASE + (stride_b << 1);
    assign cq_db    = nvme_qre_pkg::DOORBELL_BASE + stride_b + (stride_b << 1);

    assign req_end = {1'b0, r_in.start_lba} + (nvme_qre_pkg::LBA_W + 1)'(r_in.block_count);
    assign reject  = r_busy || (r_in.block_count == '0)
                  || (req_end > {1'b0, r_sector_total}) || (chunk_lim == '0);
    assign ignore  = !r_busy || (r_in.entry_status[0] != r_phase)
                  || (r_in.entry_cid != r_pending_cid);

    always_comb begin
        res_issue                  = '0;
        res_issue.kind             = nvme_qre_pkg::KIND_ISSUED;
        res_issue.opcode           = src_wr ? nvme_qre_pkg::OP_WRITE : nvme_qre_pkg::OP_READ;
        res_issue.command_id       = cid_next;
        res_issue.sq_slot          = nvme_qre_pkg::SLOT_W'(r_sq_tail);
        res_issue.cmd_lba          = src_lba;
        res_issue.blocks_minus_one = nvme_qre_pkg::BM1_W'(chunk - 1'b1);
        res_issue.doorbell_offset  = sq_db;
        res_issue.doorbell_value   = nvme_qre_pkg::SLOT_W'(tail_next);
        res_issue.last             = 1'b1;

        res_head                   = '0;
        res_head.kind              = nvme_qre_pkg::KIND_CONSUMED;
        res_head.opcode            = nvme_qre_pkg::OP_NONE;
        res_head.doorbell_offset   = cq_db;
        res_head.doorbell_value    = nvme_qre_pkg::SLOT_W'(head_next);
    end

    // ---------------------------------------------------------------------
    // Decision for the held item
    // ---------------------------------------------------------------------
    always_comb begin
        n_busy        = r_busy;
        n_remaining   = r_remaining;
        n_next_lba    = r_next_lba;
        n_write_flag  = r_write_flag;
        n_cmd_cnt     = r_cmd_cnt;
        n_pending_cid = r_pending_cid;
        n_sq_tail     = r_sq_tail;
        n_cq_head     = r_cq_head;
        n_phase       = r_phase;
        res_a         = '0;
        res_b         = '0;
        push_n        = 2'd0;
        do_issue      = 1'b0;

        if (proc_fire) begin
            priority if (r_in.action == nvme_qre_pkg::ACT_REQUEST) begin
                push_n = 2'd1;
                if (reject) begin
                    res_a.kind = nvme_qre_pkg::KIND_REJECTED;
                    res_a.last = 1'b1;
                end else begin
                    n_busy   = 1'b1;
                    do_issue = 1'b1;
                    res_a    = res_issue;
                end
            end else if (ignore) begin
                push_n     = 2'd1;
                res_a.kind = nvme_qre_pkg::KIND_IGNORED;
                res_a.last = 1'b1;
            end else if (r_in.entry_status[nvme_qre_pkg::STATUS_W-1:1] != '0) begin
                // Error status: drop the request, leave head and phase alone.
                push_n             = 2'd1;
                n_busy             = 1'b0;
                n_remaining        = '0;
                res_a.kind         = nvme_qre_pkg::KIND_FAILED;
                res_a.error_status = r_in.entry_status;
                res_a.last         = 1'b1;
            end else begin
                n_cq_head = head_next;
                if (head_next == '0) begin
                    n_phase = !r_phase;
                end
                res_a = res_head;
                if (r_remaining == '0) begin
                    push_n             = 2'd1;
                    n_busy             = 1'b0;
                    res_a.request_done = 1'b1;
                    res_a.last         = 1'b1;
                end else begin
                    push_n   = 2'd2;
                    do_issue = 1'b1;
                    res_b    = res_issue;
                end
            end
        end

        if (do_issue) begin
            n_cmd_cnt     = cid_next;
            n_pending_cid = cid_next;
            n_sq_tail     = tail_next;
            n_next_lba    = src_lba + nvme_qre_pkg::LBA_W'(chunk);
            n_remaining   = src_rem - nvme_qre_pkg::COUNT_W'(chunk);
            n_write_flag  = src_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_remaining   <= '0;
            r_next_lba    <= '0;
            r_write_flag  <= 1'b0;
            r_cmd_cnt     <= '0;
            r_pending_cid <= '0;
            r_sq_tail     <= '0;
            r_cq_head     <= '0;
            r_phase       <= 1'b1;
        end else begin
            r_busy        <= n_busy;
            r_remaining   <= n_remaining;
            r_next_lba    <= n_next_lba;
            r_write_flag  <= n_write_flag;
            r_cmd_cnt     <= n_cmd_cnt;
            r_pending_cid <= n_pending_cid;
            r_sq_tail     <= n_sq_tail;
            r_cq_head     <= n_cq_head;
            r_phase       <= n_phase;
        end
    end

    // ---------------------------------------------------------------------
    // Result FIFO
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_fifo[r_wr_ptr] <= res_a;
        end
        if (push_n == 2'd2) begin
            r_fifo[r_wr_ptr + 1'b1] <= res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + nvme_qre_pkg::FIFO_PTR_W'(push_n);
            r_rd_ptr <= r_rd_ptr + nvme_qre_pkg::FIFO_PTR_W'(pop);
            r_count  <= r_count + nvme_qre_pkg::FIFO_CNT_W'(push_n)
                      - nvme_qre_pkg::FIFO_CNT_W'(pop);
        end
    end

    assign o_kind             = r_fifo[r_rd_ptr].kind;
    assign o_opcode           = r_fifo[r_rd_ptr].opcode;
    assign o_command_id       = r_fifo[r_rd_ptr].command_id;
    assign o_sq_slot          = r_fifo[r_rd_ptr].sq_slot;
    assign o_cmd_lba          = r_fifo[r_rd_ptr].cmd_lba;
    assign o_blocks_minus_one = r_fifo[r_rd_ptr].blocks_minus_one;
    assign o_doorbell_offset  = r_fifo[r_rd_ptr].doorbell_offset;
    assign o_doorbell_value   = r_fifo[r_rd_ptr].doorbell_value;
    assign o_error_status     = r_fifo[r_rd_ptr].error_status;
    assign o_request_done     = r_fifo[r_rd_ptr].request_done;
    assign o_last             = r_fifo[r_rd_ptr].last;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `NQRE_NEVER(a_fifo_overflow, i_clk, i_rst_n,
        r_count > nvme_qre_pkg::FIFO_CNT_W'(nvme_qre_pkg::FIFO_DEPTH))
    `NQRE_ASSERT(a_busy_falls_on_completion, i_clk, i_rst_n,
        ($past(i_rst_n) && $fell(r_busy)) |->
            $past(proc_fire && (r_in.action == nvme_qre_pkg::ACT_COMPLETION)))
    `NQRE_ASSERT(a_tail_tracks_cid, i_clk, i_rst_n,
        $past(i_rst_n) |->
            (($past(r_cmd_cnt) != r_cmd_cnt) == ($past(r_sq_tail) != r_sq_tail)))
    `NQRE_ASSERT(a_issue_needs_busy, i_clk, i_rst_n,
        ($past(i_rst_n) && ($past(r_cmd_cnt) != r_cmd_cnt)) |-> r_busy)

endmodule

FILE: sim/tb_nvme_io_queue_request_engine_top.sv
// Self-checking testbench of the NVMe I/O queue request engine top level.
module tb_nvme_io_queue_request_engine_top;
    import nvme_qre_pkg::*;

    // The engine is built with its default sizes, so a chunk holds at most
    // BUF_BYTES >> lba_shift blocks and the queue indexes wrap at sixteen.
    localparam int unsigned QD           = 16;
    localparam int unsigned BUF_BYTES    = 4096;
    // A beat reaches the port only after its item has passed the input register
    // and the result FIFO, so settle() waits on before the engine is treated as quiet.
    localparam int unsigned SETTLE_CYCLES = 6;
    // The limit lies far above what a correct run needs, even with the
    // heaviest stalling.
    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned WRAP_BLOCKS  = 40;

    // Stimulus side. Every input of the engine starts at a known value.
    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  req_valid = 1'b0;
    t_item                 offer     = '0;
    logic                  res_ready = 1'b0;

    // Result side.
    logic                req_ready;
    logic                res_valid;
    logic [2:0]          res_kind;
    logic [1:0]          res_opcode;
    logic [CID_W-1:0]    res_command_id;
    logic [SLOT_W-1:0]   res_sq_slot;
    logic [LBA_W-1:0]    res_cmd_lba;
    logic [BM1_W-1:0]    res_blocks_minus_one;
    logic [DB_W-1:0]     res_doorbell_offset;
    logic [SLOT_W-1:0]   res_doorbell_value;
    logic [STATUS_W-1:0] res_error_status;
    logic                res_request_done;
    logic                res_last;

    // Our own copy of the register file. The namespace identifier shows up
    // in no result, so it is not kept.
    logic [3:0]          lba_shift_r    = 4'd9;
    logic [LBA_W-1:0]    sector_total_r = '0;
    logic [3:0]          stride_r       = 4'd0;

    // Our own copy of the queue pair state, as it stands after every item
    // that the engine has taken so far.
    logic                busy_s         = 1'b0;
    logic [COUNT_W-1:0]  remain_s       = '0;
    logic [LBA_W-1:0]    lba_s          = '0;
    logic                wr_s           = 1'b0;
    logic [CID_W-1:0]    cid_ctr        = '0;
    logic [CID_W-1:0]    cid_out        = '0;
    int unsigned         tail_s         = 0;
    int unsigned         head_s         = 0;
    logic                phase_s        = 1'b1;

    // Result beats that the engine still owes us, oldest first.
    t_result     due_beats[$];

    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;
    int unsigned gap_pct     = 0;
    int unsigned stall_pct   = 0;
    logic        hold_arm    = 1'b0;
    int unsigned hold_left   = 0;

    nvme_io_queue_request_engine_top #(
        .QUEUE_DEPTH (QD),
        .BUFFER_BYTES(BUF_BYTES)
    ) DUT (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_req_valid       (req_valid),
        .o_req_ready       (req_ready),
        .i_action          (offer.action),
        .i_start_lba       (offer.start_lba),
        .i_block_count     (offer.block_count),
        .i_is_write        (offer.is_write),
        .i_entry_cid       (offer.entry_cid),
        .i_entry_status    (offer.entry_status),
        .o_res_valid       (res_valid),
        .i_res_ready       (res_ready),
        .o_kind            (res_kind),
        .o_opcode          (res_opcode),
        .o_command_id      (res_command_id),
        .o_sq_slot         (res_sq_slot),
        .o_cmd_lba         (res_cmd_lba),
        .o_blocks_minus_one(res_blocks_minus_one),
        .o_doorbell_offset (res_doorbell_offset),
        .o_doorbell_value  (res_doorbell_value),
        .o_error_status    (res_error_status),
        .o_request_done    (res_request_done),
        .o_last            (res_last)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("nvme_io_queue_request_engine_top regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Behaviour of the queue pair.
    // ------------------------------------------------------------------

    // Largest chunk in blocks that one buffer can carry; zero when a single
    // block is bigger than the buffer. It saturates so the length field fits.
    function automatic int unsigned chunk_cap();
        int unsigned m;
        m = BUF_BYTES >> lba_shift_r;
        if (m > MAX_CHUNK) m = MAX_CHUNK;
        return m;
    endfunction

    // Doorbell register offset: the submission doorbell of queue one sits two
    // strides above the base, the completion doorbell three.
    function automatic logic [DB_W-1:0] doorbell_at(input int unsigned mult);
        logic [63:0] v;
        v = 64'(DOORBELL_BASE) + 64'(mult) * (64'd4 << stride_r);
        return v[DB_W-1:0];
    endfunction

    // Takes the next command ID and tail slot and carves the next chunk off
    // the outstanding request.
    task automatic issue_next_chunk(output t_result r);
        int unsigned      lim;
        int unsigned      chunk;
        int unsigned      slot;
        logic [LBA_W-1:0] first;
        lim   = chunk_cap();
        chunk = (remain_s > lim) ? lim : remain_s;
        slot  = tail_s;
        first = lba_s;
        cid_ctr  = cid_ctr + 16'd1;
        cid_out  = cid_ctr;
        tail_s   = (slot + 1) % QD;
        lba_s    = lba_s + chunk;
        remain_s = remain_s - chunk;
        r = '0;
        r.kind             = KIND_ISSUED;
        r.opcode           = wr_s ? OP_WRITE : OP_READ;
        r.command_id       = cid_out;
        r.sq_slot          = slot[SLOT_W-1:0];
        r.cmd_lba          = first;
        r.blocks_minus_one = BM1_W'(chunk - 1);
        r.doorbell_offset  = doorbell_at(2);
        r.doorbell_value   = tail_s[SLOT_W-1:0];
        r.last             = 1'b1;
    endtask

    // Applies one accepted item to our copy of the state and queues the
    // beats it must produce.
    task automatic advance_queue_pair(input t_item it);
        t_result     r;
        logic [63:0] reach;
        r = '0;
        r.last = 1'b1;
        if (it.action == ACT_REQUEST) begin
            reach = {16'd0, it.start_lba} + {32'd0, it.block_count};
            if (busy_s || it.block_count == '0 || reach > {16'd0, sector_total_r} ||
                chunk_cap() == 0) begin
                r.kind = KIND_REJECTED;
                due_beats.push_back(r);
            end else begin
                busy_s   = 1'b1;
                remain_s = it.block_count;
                lba_s    = it.start_lba;
                wr_s     = it.is_write;
                issue_next_chunk(r);
                due_beats.push_back(r);
            end
        end else if (!busy_s || it.entry_status[0] != phase_s || it.entry_cid != cid_out) begin
            r.kind = KIND_IGNORED;
            due_beats.push_back(r);
        end else if (it.entry_status[STATUS_W-1:1] != '0) begin
            // A bad status drops the request; head and phase stay put.
            busy_s         = 1'b0;
            remain_s       = '0;
            r.kind         = KIND_FAILED;
            r.error_status = it.entry_status;
            due_beats.push_back(r);
        end else begin
            head_s = (head_s + 1) % QD;
            if (head_s == 0) phase_s = ~phase_s;
            r.kind            = KIND_CONSUMED;
            r.doorbell_offset = doorbell_at(3);
            r.doorbell_value  = head_s[SLOT_W-1:0];
            if (remain_s == '0) begin
                busy_s         = 1'b0;
                r.request_done = 1'b1;
                due_beats.push_back(r);
            end else begin
                r.last = 1'b0;
                due_beats.push_back(r);
                issue_next_chunk(r);
                due_beats.push_back(r);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: the receiver and the beat check.
    // ------------------------------------------------------------------

    // The receiver stalls at random, or holds off completely for a long
    // stretch once armed, so that the result FIFO fills and the request
    // channel backs up.
    always @(posedge clk) begin
        if (hold_arm) begin
            hold_left = HOLD_CYCLES;
            hold_arm <= 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ready <= 1'b0;
        end else begin
            res_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Every beat taken from the engine is held against the oldest one owed.
    always @(posedge clk) begin : beat_check
        t_result want;
        if (rst_n && res_valid && res_ready) begin
            if (due_beats.size() == 0) begin
                $error("result beat of kind %0d arrived with nothing outstanding", res_kind);
                mismatches++;
            end else begin
                want = due_beats.pop_front();
                check_field("kind", want.kind, res_kind);
                check_field("opcode", want.opcode, res_opcode);
                check_field("command_id", want.command_id, res_command_id);
                check_field("sq_slot", want.sq_slot, res_sq_slot);
                check_field("cmd_lba", want.cmd_lba, res_cmd_lba);
                check_field("blocks_minus_one", want.blocks_minus_one, res_blocks_minus_one);
                check_field("doorbell_offset", want.doorbell_offset, res_doorbell_offset);
                check_field("doorbell_value", want.doorbell_value, res_doorbell_value);
                check_field("error_status", want.error_status, res_error_status);
                check_field("request_done", want.request_done, res_request_done);
                check_field("last", want.last, res_last);
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side.
    // ------------------------------------------------------------------

    function automatic logic [LBA_W-1:0] rand48();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[LBA_W-1:0];
    endfunction

    // A block request; the completion fields carry random noise.
    function automatic t_item mk_request(input logic [LBA_W-1:0] start,
                                         input logic [COUNT_W-1:0] count,
                                         input logic wr);
        t_item it;
        it.action       = ACT_REQUEST;
        it.start_lba    = start;
        it.block_count  = count;
        it.is_write     = wr;
        it.entry_cid    = CID_W'($urandom());
        it.entry_status = STATUS_W'($urandom());
        return it;
    endfunction

    // A completion entry; the request fields carry random noise.
    function automatic t_item mk_entry(input logic [CID_W-1:0] cid,
                                       input logic [STATUS_W-1:0] status);
        t_item it;
        it.action       = ACT_COMPLETION;
        it.start_lba    = rand48();
        it.block_count  = $urandom();
        it.is_write     = 1'($urandom_range(1));
        it.entry_cid    = cid;
        it.entry_status = status;
        return it;
    endfunction

    // The completion the host would see for the outstanding command.
    function automatic t_item good_entry();
        return mk_entry(cid_out, {15'd0, phase_s});
    endfunction

    // Offers one item and waits until the engine takes it. An optional idle
    // gap goes first; without one, valid simply stays high from the last
    // item so back-to-back items keep the channel busy.
    task automatic offer_item(input t_item it);
        if ($urandom_range(99) < gap_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < gap_pct) @(posedge clk);
        end
        req_valid <= 1'b1;
        offer     <= it;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        advance_queue_pair(it);
    endtask

    // Stops offering and waits until every owed beat has arrived and the
    // engine has had time to fall quiet.
    task automatic settle();
        req_valid <= 1'b0;
        while (due_beats.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register writes happen only with the engine quiet and no request open;
    // an open request is first failed with a bad status.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        settle();
        if (busy_s) begin
            offer_item(mk_entry(cid_out, {15'd1, phase_s}));
            settle();
        end
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_LBA_SHIFT:    lba_shift_r    = data[3:0];
            REG_SECTOR_TOTAL: sector_total_r = data[LBA_W-1:0];
            REG_NAMESPACE:    ;
            REG_STRIDE_SHIFT: stride_r       = data[3:0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Short walk through the edges: rejection for each reason, stale and
    // mismatched completions, multi-chunk requests, a failure, the largest
    // chunk and a block too big for the buffer.
    task automatic test_directed_cases();
        gap_pct   = 0;
        stall_pct = 0;
        // After reset the namespace is empty, so any request is refused.
        offer_item(mk_request('0, 32'd1, 1'b0));
        // A completion with no request open is ignored.
        offer_item(mk_entry('0, 16'd1));

        write_reg(REG_SECTOR_TOTAL, '1);
        write_reg(REG_LBA_SHIFT, 48'd9);
        write_reg(REG_STRIDE_SHIFT, 48'd15);
        write_reg(REG_NAMESPACE, 48'hFFFF_FFFF);

        offer_item(mk_request(48'd5, 32'd0, 1'b0));
        // Starting one past the last block, even a single block runs past the end.
        offer_item(mk_request('1, 32'd1, 1'b1));
        offer_item(mk_request(48'hFFFF_FFFF_FFFE, 32'd1, 1'b0));
        offer_item(good_entry());

        // Twenty blocks in chunks of eight: three commands.
        offer_item(mk_request('0, 32'd20, 1'b1));
        offer_item(mk_entry(cid_out, {15'd0, ~phase_s}));
        offer_item(mk_entry(cid_out + 16'd1, {15'd0, phase_s}));
        offer_item(mk_request('1, '1, 1'b1));
        offer_item(good_entry());
        offer_item(good_entry());
        offer_item(good_entry());

        // A read that fails with every status bit set.
        offer_item(mk_request(48'd1000, 32'd10, 1'b0));
        offer_item(mk_entry(cid_out, {15'h7FFF, phase_s}));
        offer_item(good_entry());

        // One-byte blocks: the chunk reaches its ceiling of 4096 blocks.
        write_reg(REG_LBA_SHIFT, 48'd0);
        write_reg(REG_STRIDE_SHIFT, 48'd0);
        write_reg(REG_NAMESPACE, 48'd0);
        offer_item(mk_request('0, 32'd5000, 1'b1));
        offer_item(good_entry());
        offer_item(good_entry());

        // Blocks larger than the buffer leave no room for a chunk at all.
        write_reg(REG_LBA_SHIFT, 48'd15);
        offer_item(mk_request('0, 32'd1, 1'b0));
        write_reg(REG_LBA_SHIFT, 48'd13);
        offer_item(mk_request('0, 32'd1, 1'b1));
    endtask

    // Mostly well-formed request and completion sequences with random
    // content, salted with stale, mismatched and failing entries and with
    // requests that must be refused.
    task automatic test_random_traffic(input int unsigned gap, input int unsigned stall,
                                       input int unsigned n);
        t_item       it;
        int unsigned roll;
        int unsigned sel;
        logic [63:0] limit;
        logic [63:0] cnt;
        logic [63:0] st;
        logic [LBA_W-1:0] total;
        gap_pct   = gap;
        stall_pct = stall;

        sel = $urandom_range(9);
        write_reg(REG_LBA_SHIFT, (sel == 0) ? 48'd15 : 48'($urandom_range(12)));
        sel = $urandom_range(9);
        if (sel < 4) total = '1;
        else if (sel < 7) total = rand48();
        else total = LBA_W'($urandom_range(200, 1));
        write_reg(REG_SECTOR_TOTAL, total);
        write_reg(REG_NAMESPACE, 48'($urandom()));
        write_reg(REG_STRIDE_SHIFT, 48'($urandom_range(15)));

        repeat (n) begin
            roll = $urandom_range(99);
            if (busy_s) begin
                if (roll < 70) it = good_entry();
                else if (roll < 78)
                    it = mk_entry(cid_out, {15'($urandom_range(32767, 1)), phase_s});
                else if (roll < 85)
                    it = mk_entry(cid_out ^ 16'($urandom_range(65535, 1)),
                                  {15'($urandom()), phase_s});
                else if (roll < 90)
                    it = mk_entry(cid_out, {15'($urandom()), ~phase_s});
                else
                    it = mk_request(rand48(), $urandom(), 1'($urandom_range(1)));
            end else begin
                if (roll < 75) begin
                    // Up to three chunks, kept inside the namespace.
                    limit = 64'(3 * chunk_cap());
                    if (limit > 64'(sector_total_r)) limit = 64'(sector_total_r);
                    if (limit == 0) cnt = 64'($urandom_range(16, 1));
                    else cnt = 64'($urandom_range(int'(limit), 1));
                    if (cnt <= 64'(sector_total_r))
                        st = 64'(rand48()) % (64'(sector_total_r) - cnt + 1);
                    else
                        st = 64'(rand48());
                    it = mk_request(st[LBA_W-1:0], cnt[COUNT_W-1:0], 1'($urandom_range(1)));
                end else if (roll < 85) begin
                    it = mk_request(sector_total_r,
                                    $urandom_range(1) ? 32'd0 : 32'($urandom_range(4096, 1)),
                                    1'($urandom_range(1)));
                end else begin
                    it = mk_entry(CID_W'($urandom()), STATUS_W'($urandom()));
                end
            end
            offer_item(it);
        end
    endtask

    // The receiver holds off for a long stretch while items keep coming, so
    // the result FIFO fills and the request channel has to stall.
    task automatic test_backpressure();
        logic [COUNT_W-1:0] cnt;
        gap_pct   = 0;
        stall_pct = 0;
        write_reg(REG_LBA_SHIFT, 48'd9);
        write_reg(REG_SECTOR_TOTAL, '1);
        hold_arm <= 1'b1;
        repeat (40) begin
            if (busy_s) begin
                offer_item(good_entry());
            end else begin
                cnt = COUNT_W'($urandom_range(40, 1));
                offer_item(mk_request(rand48() >> 1, cnt, 1'($urandom_range(1))));
            end
        end
    endtask

    // One-block chunks of one long request carry the submission tail and
    // the completion head round the queue more than twice, flipping the phase.
    task automatic test_queue_index_wrap();
        logic [63:0] st;
        gap_pct   = 0;
        stall_pct = 0;
        write_reg(REG_LBA_SHIFT, 48'd12);
        write_reg(REG_SECTOR_TOTAL, '1);
        st = 64'(rand48()) % (64'h0000_FFFF_FFFF_FFFF - 64'(WRAP_BLOCKS) + 1);
        offer_item(mk_request(st[LBA_W-1:0], WRAP_BLOCKS, 1'b1));
        while (busy_s) offer_item(good_entry());
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_traffic(0, 0, 270);
        test_random_traffic(53, 0, 270);
        test_random_traffic(0, 53, 270);
        test_random_traffic(7, 7, 270);
        test_backpressure();
        test_queue_index_wrap();
        settle();
        if (mismatches == 0) begin
            $display("nvme_io_queue_request_engine_top regression: pass");
        end else begin
            $display("nvme_io_queue_request_engine_top regression: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/nvme_qre_pkg.sv
design/nvme_io_queue_request_engine_top.sv
sim/tb_nvme_io_queue_request_engine_top.sv
